FILE: rtl/usb_control_setup_responder_macros.svh
// Assertion macros for the endpoint-0 responder controller.
`ifndef USB_CONTROL_SETUP_RESPONDER_MACROS_SVH
`define USB_CONTROL_SETUP_RESPONDER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define UCSR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ucsr: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define UCSR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ucsr: next-cycle check failed");

`endif

FILE: rtl/ucsr_pkg.sv
// Shared types, codes, descriptor layout and descriptor ROM of the endpoint-0 responder.
package ucsr_pkg;

  localparam int MAX_PACKET_BYTES = 64;
  localparam int ROM_BYTES        = 128;
  localparam int ROM_AW           = $clog2(ROM_BYTES);
  localparam int CNT_W            = 7;

  // event codes
  localparam logic [1:0] CMD_SETUP    = 2'd0;
  localparam logic [1:0] CMD_OUT_RX   = 2'd1;
  localparam logic [1:0] CMD_IN_DONE  = 2'd2;
  localparam logic [1:0] CMD_BUS_RST  = 2'd3;

  // response kinds
  localparam logic [1:0] KIND_DATA    = 2'd0;
  localparam logic [1:0] KIND_ZLP     = 2'd1;
  localparam logic [1:0] KIND_STALL   = 2'd2;
  localparam logic [1:0] KIND_NONE    = 2'd3;

  // endpoint states
  localparam logic [1:0] EP_DISABLED  = 2'd0;
  localparam logic [1:0] EP_STALL     = 2'd1;
  localparam logic [1:0] EP_NAK       = 2'd2;
  localparam logic [1:0] EP_VALID     = 2'd3;

  // request fields
  localparam logic [7:0] RT_DEV_IN        = 8'h80;
  localparam logic [7:0] RT_DEV_OUT       = 8'h00;
  localparam logic [7:0] REQ_SET_ADDRESS  = 8'h05;
  localparam logic [7:0] REQ_GET_DESC     = 8'h06;
  localparam logic [7:0] REQ_SET_CONFIG   = 8'h09;

  localparam logic [15:0] DV_DEVICE   = 16'h0100;
  localparam logic [15:0] DV_CONFIG   = 16'h0200;
  localparam logic [15:0] DV_LANG     = 16'h0300;
  localparam logic [15:0] DV_VSTR     = 16'h0301;
  localparam logic [15:0] DV_PSTR     = 16'h0302;

  // configuration register indexes
  localparam logic CFG_VENDOR_ID  = 1'b0;
  localparam logic CFG_PRODUCT_ID = 1'b1;

  localparam logic [15:0] VENDOR_ID_RST  = 16'hf055;
  localparam logic [15:0] PRODUCT_ID_RST = 16'h0002;

  // descriptor layout in the ROM
  localparam logic [ROM_AW-1:0] DEV_OFS  = ROM_AW'(0);
  localparam logic [ROM_AW-1:0] CFG_OFS  = ROM_AW'(18);
  localparam logic [ROM_AW-1:0] LANG_OFS = ROM_AW'(50);
  localparam logic [ROM_AW-1:0] VSTR_OFS = ROM_AW'(54);
  localparam logic [ROM_AW-1:0] PSTR_OFS = ROM_AW'(58);

  localparam logic [CNT_W-1:0] DEV_LEN  = CNT_W'(18);
  localparam logic [CNT_W-1:0] CFG_LEN  = CNT_W'(32);
  localparam logic [CNT_W-1:0] LANG_LEN = CNT_W'(4);
  localparam logic [CNT_W-1:0] VSTR_LEN = CNT_W'(10);
  localparam logic [CNT_W-1:0] PSTR_LEN = CNT_W'(14);
  localparam logic [CNT_W-1:0] MAX_PKT  = CNT_W'(MAX_PACKET_BYTES);

  typedef enum logic [2:0] {
    SEL_DEV  = 3'd0,
    SEL_CFG  = 3'd1,
    SEL_LANG = 3'd2,
    SEL_VSTR = 3'd3,
    SEL_PSTR = 3'd4
  } desc_sel_e;

  typedef enum logic [1:0] {
    FSM_IDLE   = 2'b01,
    FSM_STREAM = 2'b10
  } fsm_e;

  typedef struct packed {
    logic load_single;
    logic start_stream;
    logic emit_byte;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic in_stream;
    logic stream_last;
  } dp_stat_t;

  function automatic logic [7:0] rom_byte(input logic [ROM_AW-1:0] a);
    logic [7:0] b;
    b = 8'h00;
    case (a)
      ROM_AW'(0):  b = 8'd18;
      ROM_AW'(1):  b = 8'd1;
      ROM_AW'(3):  b = 8'h02;
      ROM_AW'(4):  b = 8'hff;
      ROM_AW'(5):  b = 8'hff;
      ROM_AW'(6):  b = 8'hff;
      ROM_AW'(14): b = 8'd1;
      ROM_AW'(15): b = 8'd2;
      ROM_AW'(17): b = 8'd1;
      ROM_AW'(18): b = 8'd9;
      ROM_AW'(19): b = 8'd2;
      ROM_AW'(20): b = 8'd32;
      ROM_AW'(22): b = 8'd1;
      ROM_AW'(23): b = 8'd1;
      ROM_AW'(25): b = 8'h80;
      ROM_AW'(26): b = 8'd50;
      ROM_AW'(27): b = 8'd9;
      ROM_AW'(28): b = 8'd4;
      ROM_AW'(31): b = 8'd2;
      ROM_AW'(32): b = 8'hff;
      ROM_AW'(33): b = 8'hff;
      ROM_AW'(34): b = 8'hff;
      ROM_AW'(36): b = 8'd7;
      ROM_AW'(37): b = 8'd5;
      ROM_AW'(38): b = 8'h81;
      ROM_AW'(39): b = 8'd2;
      ROM_AW'(40): b = 8'd64;
      ROM_AW'(42): b = 8'd1;
      ROM_AW'(43): b = 8'd7;
      ROM_AW'(44): b = 8'd5;
      ROM_AW'(45): b = 8'h02;
      ROM_AW'(46): b = 8'd2;
      ROM_AW'(47): b = 8'd64;
      ROM_AW'(49): b = 8'd1;
      ROM_AW'(50): b = 8'd4;
      ROM_AW'(51): b = 8'd3;
      ROM_AW'(52): b = 8'h09;
      ROM_AW'(53): b = 8'h04;
      ROM_AW'(54): b = 8'h4f;
      ROM_AW'(55): b = 8'h53;
      ROM_AW'(56): b = 8'h52;
      ROM_AW'(57): b = 8'h46;
      ROM_AW'(58): b = 8'h72;
      ROM_AW'(59): b = 8'h6f;
      ROM_AW'(60): b = 8'h73;
      ROM_AW'(61): b = 8'h63;
      ROM_AW'(62): b = 8'h61;
      ROM_AW'(63): b = 8'h72;
      default:     b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

FILE: rtl/usb_control_setup_responder.sv
// Top level of the endpoint-0 standard request responder.
//
//  channel   direction  tdata                                   tuser / tlast
//  s_axis    in         type, code, value, length               tuser: cmd
//  m_axis    out        data byte, address, rx/tx status        tuser: kind, bad; tlast
//  cfg       in         write only: vendor id, product id       -
//
// Single-result events are registered and show up on m_axis the cycle after they are accepted.
// A descriptor response is decoded when the request is accepted and then streamed out byte
// by byte (up to 32 bytes here), paced by the single output register.
// The next request is taken once the controller is idle again and the output slot is free.
// m_axis_tready low holds the byte sequencer; reset clears endpoint state,
// addresses and the configuration registers to their defaults.
module usb_control_setup_responder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // req_type, request_code, req_value, request_length
  input  logic [1:0]  s_axis_tuser,   // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // data_byte, device_address, rx_state, tx_status, zero pad
  output logic [2:0]  m_axis_tuser,   // response_kind, bad_request
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);

  ucsr_pkg::ctrl_cmd_t ctl_cmd;
  ucsr_pkg::dp_stat_t  dp_stat;

  logic [1:0] response_kind, rx_state, tx_status;
  logic [7:0] data_byte;
  logic [6:0] device_address;
  logic       bad_request;

  ucsr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (dp_stat),
    .cmd_o      (ctl_cmd)
  );

  ucsr_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .cmd_i            (s_axis_tuser),
    .req_type_i       (s_axis_tdata[7:0]),
    .request_code_i   (s_axis_tdata[15:8]),
    .req_value_i      (s_axis_tdata[31:16]),
    .request_length_i (s_axis_tdata[47:32]),
    .out_ready_i      (m_axis_tready),
    .out_valid_o      (m_axis_tvalid),
    .response_kind_o  (response_kind),
    .data_byte_o      (data_byte),
    .last_o           (m_axis_tlast),
    .device_address_o (device_address),
    .rx_state_o       (rx_state),
    .tx_status_o      (tx_status),
    .bad_request_o    (bad_request),
    .ctl_cmd_i        (ctl_cmd),
    .stat_o           (dp_stat)
  );

  assign m_axis_tdata = {5'd0, tx_status, rx_state, device_address, data_byte};
  assign m_axis_tuser = {bad_request, response_kind};

endmodule

FILE: rtl/ucsr_ctrl.sv
// Controller state machine: request acceptance and descriptor byte sequencing.
`include "usb_control_setup_responder_macros.svh"

module ucsr_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  ucsr_pkg::dp_stat_t   stat_i,
  output ucsr_pkg::ctrl_cmd_t  cmd_o
);

  ucsr_pkg::fsm_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ucsr_pkg::FSM_IDLE: begin
        in_ready_o = stat_i.out_free;
        if (in_valid_i && stat_i.out_free) begin
          if (stat_i.in_stream) begin
            cmd_o.start_stream = 1'b1;
            state_d            = ucsr_pkg::FSM_STREAM;
          end else begin
            cmd_o.load_single = 1'b1;
          end
        end
      end
      ucsr_pkg::FSM_STREAM: begin
        // advance one byte whenever the output slot frees up
        cmd_o.emit_byte = stat_i.out_free;
        if (stat_i.out_free && stat_i.stream_last) begin
          state_d = ucsr_pkg::FSM_IDLE;
        end
      end
      default: begin
        state_d = ucsr_pkg::FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ucsr_pkg::FSM_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `UCSR_ASSERT_NXT(a_start_enters_stream, clk_i, rst_ni, cmd_o.start_stream,
                   state_q == ucsr_pkg::FSM_STREAM)
  `UCSR_ASSERT_IMP(a_emit_only_streaming, clk_i, rst_ni, cmd_o.emit_byte,
                   state_q == ucsr_pkg::FSM_STREAM)
  `UCSR_ASSERT_NXT(a_last_byte_ends, clk_i, rst_ni, cmd_o.emit_byte && stat_i.stream_last,
                   state_q == ucsr_pkg::FSM_IDLE)
  `UCSR_ASSERT_NXT(a_stall_holds_stream, clk_i, rst_ni,
                   state_q == ucsr_pkg::FSM_STREAM && !stat_i.out_free,
                   state_q == ucsr_pkg::FSM_STREAM)

endmodule

FILE: rtl/ucsr_dp.sv
// Datapath: request decode, endpoint state, descriptor bytes and output register.
module ucsr_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [15:0]          cfg_wdata_i,
  input  logic [1:0]           cmd_i,
  input  logic [7:0]           req_type_i,
  input  logic [7:0]           request_code_i,
  input  logic [15:0]          req_value_i,
  input  logic [15:0]          request_length_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [1:0]           response_kind_o,
  output logic [7:0]           data_byte_o,
  output logic                 last_o,
  output logic [6:0]           device_address_o,
  output logic [1:0]           rx_state_o,
  output logic [1:0]           tx_status_o,
  output logic                 bad_request_o,
  input  ucsr_pkg::ctrl_cmd_t  ctl_cmd_i,
  output ucsr_pkg::dp_stat_t   stat_o
);

  localparam int CW = ucsr_pkg::CNT_W;
  localparam int AW = ucsr_pkg::ROM_AW;

  logic [15:0] vendor_q, product_q;
  logic [6:0]  applied_q, applied_d;
  logic [6:0]  pending_q, pending_d;
  logic [1:0]  rx_q, rx_d, tx_q, tx_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] len_q;
  ucsr_pkg::desc_sel_e sel_q;

  logic        ovalid_q;
  logic [1:0]  okind_q;
  logic [7:0]  obyte_q;
  logic        olast_q;
  logic [6:0]  oaddr_q;
  logic [1:0]  orx_q, otx_q;
  logic        obad_q;

  logic        get_desc, desc_known;
  ucsr_pkg::desc_sel_e sel_d;
  logic [CW-1:0] dlen, nlen_raw, nlen;
  logic [1:0]  kind_d;
  logic        bad_d;
  logic [CW-1:0] cnt_inc;
  logic [AW-1:0] rom_addr;
  logic [7:0]  rom_data, desc_byte;
  logic        accept;

  // descriptor decode
  always_comb begin
    get_desc   = (req_type_i == ucsr_pkg::RT_DEV_IN) &&
                 (request_code_i == ucsr_pkg::REQ_GET_DESC);
    desc_known = 1'b1;
    sel_d      = ucsr_pkg::SEL_DEV;
    dlen       = ucsr_pkg::DEV_LEN;
    case (req_value_i)
      ucsr_pkg::DV_DEVICE: begin
        sel_d = ucsr_pkg::SEL_DEV;
        dlen  = ucsr_pkg::DEV_LEN;
      end
      ucsr_pkg::DV_CONFIG: begin
        sel_d = ucsr_pkg::SEL_CFG;
        dlen  = ucsr_pkg::CFG_LEN;
      end
      ucsr_pkg::DV_LANG: begin
        sel_d = ucsr_pkg::SEL_LANG;
        dlen  = ucsr_pkg::LANG_LEN;
      end
      ucsr_pkg::DV_VSTR: begin
        sel_d = ucsr_pkg::SEL_VSTR;
        dlen  = ucsr_pkg::VSTR_LEN;
      end
      ucsr_pkg::DV_PSTR: begin
        sel_d = ucsr_pkg::SEL_PSTR;
        dlen  = ucsr_pkg::PSTR_LEN;
      end
      default: begin
        desc_known = 1'b0;
      end
    endcase
    nlen_raw = (request_length_i < {{(16-CW){1'b0}}, dlen}) ? request_length_i[CW-1:0] : dlen;
    nlen     = (nlen_raw > ucsr_pkg::MAX_PKT) ? ucsr_pkg::MAX_PKT : nlen_raw;
  end

  // next endpoint state for any accepted event
  always_comb begin
    applied_d = applied_q;
    pending_d = pending_q;
    rx_d      = rx_q;
    tx_d      = tx_q;
    cnt_d     = cnt_q;
    kind_d    = ucsr_pkg::KIND_NONE;
    bad_d     = 1'b0;
    case (cmd_i)
      ucsr_pkg::CMD_OUT_RX: begin
        rx_d = ucsr_pkg::EP_VALID;
      end
      ucsr_pkg::CMD_IN_DONE: begin
        rx_d = ucsr_pkg::EP_VALID;
        tx_d = ucsr_pkg::EP_NAK;
        if (pending_q != 7'd0) begin
          applied_d = pending_q;
          pending_d = 7'd0;
        end
      end
      ucsr_pkg::CMD_BUS_RST: begin
        applied_d = 7'd0;
        rx_d      = ucsr_pkg::EP_VALID;
        tx_d      = ucsr_pkg::EP_NAK;
        cnt_d     = '0;
      end
      ucsr_pkg::CMD_SETUP: begin
        rx_d = ucsr_pkg::EP_NAK;
        if (get_desc) begin
          if (desc_known) begin
            tx_d   = ucsr_pkg::EP_VALID;
            cnt_d  = nlen;
            kind_d = ucsr_pkg::KIND_ZLP;
          end else begin
            tx_d   = ucsr_pkg::EP_STALL;
            rx_d   = ucsr_pkg::EP_VALID;
            kind_d = ucsr_pkg::KIND_STALL;
          end
        end else if ((req_type_i == ucsr_pkg::RT_DEV_OUT) &&
                     (request_code_i == ucsr_pkg::REQ_SET_ADDRESS)) begin
          pending_d = req_value_i[6:0];
          tx_d      = ucsr_pkg::EP_VALID;
          kind_d    = ucsr_pkg::KIND_ZLP;
        end else if ((req_type_i == ucsr_pkg::RT_DEV_OUT) &&
                     (request_code_i == ucsr_pkg::REQ_SET_CONFIG)) begin
          tx_d   = ucsr_pkg::EP_VALID;
          kind_d = ucsr_pkg::KIND_ZLP;
        end else begin
          tx_d   = ucsr_pkg::EP_STALL;
          rx_d   = ucsr_pkg::EP_VALID;
          kind_d = ucsr_pkg::KIND_STALL;
          bad_d  = 1'b1;
        end
      end
      default: begin
        kind_d = ucsr_pkg::KIND_NONE;
      end
    endcase
  end

  // descriptor byte at the current stream position
  always_comb begin
    rom_addr  = cnt_q;
    desc_byte = 8'h00;
    case (sel_q)
      ucsr_pkg::SEL_DEV:  rom_addr = ucsr_pkg::DEV_OFS + cnt_q;
      ucsr_pkg::SEL_CFG:  rom_addr = ucsr_pkg::CFG_OFS + cnt_q;
      ucsr_pkg::SEL_LANG: rom_addr = ucsr_pkg::LANG_OFS + cnt_q;
      ucsr_pkg::SEL_VSTR: rom_addr = ucsr_pkg::VSTR_OFS + {1'b0, cnt_q[CW-1:1]} - AW'(1);
      ucsr_pkg::SEL_PSTR: rom_addr = ucsr_pkg::PSTR_OFS + {1'b0, cnt_q[CW-1:1]} - AW'(1);
      default:            rom_addr = cnt_q;
    endcase
    rom_data = ucsr_pkg::rom_byte(rom_addr);
    case (sel_q)
      ucsr_pkg::SEL_DEV: begin
        case (cnt_q)
          CW'(7):  desc_byte = 8'(ucsr_pkg::MAX_PACKET_BYTES);
          CW'(8):  desc_byte = vendor_q[7:0];
          CW'(9):  desc_byte = vendor_q[15:8];
          CW'(10): desc_byte = product_q[7:0];
          CW'(11): desc_byte = product_q[15:8];
          default: desc_byte = rom_data;
        endcase
      end
      ucsr_pkg::SEL_VSTR, ucsr_pkg::SEL_PSTR: begin
        // UTF-16LE: length, type, then ASCII low byte with a zero high byte
        if (cnt_q == CW'(0)) begin
          desc_byte = (sel_q == ucsr_pkg::SEL_VSTR) ? 8'(ucsr_pkg::VSTR_LEN)
                                                    : 8'(ucsr_pkg::PSTR_LEN);
        end else if (cnt_q == CW'(1)) begin
          desc_byte = 8'd3;
        end else if (cnt_q[0]) begin
          desc_byte = 8'h00;
        end else begin
          desc_byte = rom_data;
        end
      end
      default: desc_byte = rom_data;
    endcase
  end

  assign accept  = ctl_cmd_i.load_single | ctl_cmd_i.start_stream;
  assign cnt_inc = cnt_q + CW'(1);

  assign stat_o.out_free    = !ovalid_q || out_ready_i;
  assign stat_o.in_stream   = (cmd_i == ucsr_pkg::CMD_SETUP) && get_desc && desc_known &&
                              (nlen != '0);
  assign stat_o.stream_last = (cnt_inc == len_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vendor_q  <= ucsr_pkg::VENDOR_ID_RST;
      product_q <= ucsr_pkg::PRODUCT_ID_RST;
      applied_q <= 7'd0;
      pending_q <= 7'd0;
      rx_q      <= ucsr_pkg::EP_VALID;
      tx_q      <= ucsr_pkg::EP_NAK;
      cnt_q     <= '0;
      ovalid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == ucsr_pkg::CFG_VENDOR_ID) begin
          vendor_q <= cfg_wdata_i;
        end else begin
          product_q <= cfg_wdata_i;
        end
      end
      if (accept) begin
        applied_q <= applied_d;
        pending_q <= pending_d;
        rx_q      <= rx_d;
        tx_q      <= tx_d;
        cnt_q     <= ctl_cmd_i.start_stream ? '0 : cnt_d;
      end else if (ctl_cmd_i.emit_byte) begin
        cnt_q <= cnt_inc;
      end
      if (ctl_cmd_i.load_single || ctl_cmd_i.emit_byte) begin
        ovalid_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (ctl_cmd_i.start_stream) begin
      len_q <= nlen;
      sel_q <= sel_d;
    end
    if (ctl_cmd_i.load_single) begin
      okind_q <= kind_d;
      obyte_q <= 8'h00;
      olast_q <= 1'b1;
      oaddr_q <= applied_d;
      orx_q   <= rx_d;
      otx_q   <= tx_d;
      obad_q  <= bad_d;
    end else if (ctl_cmd_i.emit_byte) begin
      okind_q <= ucsr_pkg::KIND_DATA;
      obyte_q <= desc_byte;
      olast_q <= stat_o.stream_last;
      oaddr_q <= applied_q;
      orx_q   <= rx_q;
      otx_q   <= tx_q;
      obad_q  <= 1'b0;
    end
  end

  assign out_valid_o      = ovalid_q;
  assign response_kind_o  = okind_q;
  assign data_byte_o      = obyte_q;
  assign last_o           = olast_q;
  assign device_address_o = oaddr_q;
  assign rx_state_o       = orx_q;
  assign tx_status_o      = otx_q;
  assign bad_request_o    = obad_q;

endmodule
